// ----- hdl/pct_pkg.sv -----
// Shared types, constants and helper functions of the printer code translator.
// No dependencies; every other file of the block imports this package.
package pct_pkg;

	localparam int SEQ_LEN   = 8;
	localparam int MODES     = 8;
	localparam int EXT_CODES = 128;

	localparam int POS_W  = $clog2(SEQ_LEN);
	localparam int MODE_W = $clog2(MODES);
	localparam int CODE_W = $clog2(EXT_CODES);

	localparam logic [7:0] BYTE_NULL  = 8'd255;
	localparam logic [7:0] BYTE_EXT   = 8'd128;
	localparam logic [7:0] BYTE_TOP   = 8'd254;
	localparam logic [7:0] BYTE_SPACE = 8'h20;

	localparam logic [1:0] REQ_PRINT    = 2'd0;
	localparam logic [1:0] REQ_LD_CSEQ  = 2'd1;
	localparam logic [1:0] REQ_LD_CMODE = 2'd2;
	localparam logic [1:0] REQ_LD_MSEQ  = 2'd3;

	typedef logic [2:0] kind_t;

	localparam kind_t K_LD_CSEQ  = 3'd0;
	localparam kind_t K_LD_CMODE = 3'd1;
	localparam kind_t K_LD_START = 3'd2;
	localparam kind_t K_LD_END   = 3'd3;
	localparam kind_t K_PR_NULL  = 3'd4;
	localparam kind_t K_PR_EXT   = 3'd5;
	localparam kind_t K_PR_PLAIN = 3'd6;

	typedef logic [SEQ_LEN-1:0][7:0] row_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		logic [CODE_W-1:0] code;
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  pos;
	} item_t;

	typedef struct packed {
		logic full;
		logic clearing;
	} flow_t;

	// Remainder by MODES through a short chain of compare and subtract steps.
	function automatic logic [MODE_W-1:0] mode_mod(input logic [7:0] v);
		int r;
		r = int'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (MODES << k)) begin
				r = r - (MODES << k);
			end
		end
		return MODE_W'(r);
	endfunction

	// A start or end sequence made of one space alone is not sent.
	function automatic logic is_space(input row_t r);
		return (r[0] == BYTE_SPACE) && (r[1] == 8'd0);
	endfunction

endpackage

// ----- hdl/pct_front.sv -----
// Front end of the printer code translator: takes input words and classifies them.
// Depends on pct_pkg; feeds pct_queue.
module pct_front (
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      req_type,
	input  logic [7:0]      data_byte,
	input  logic [6:0]      code_index,
	input  logic [2:0]      mode_index,
	input  logic            which_seq,
	input  logic [2:0]      seq_pos,
	input  pct_pkg::flow_t  flow,
	output logic            push,
	output pct_pkg::item_t  item
);
	import pct_pkg::*;

	logic keep;

	always_comb begin
		item.kind = K_PR_PLAIN;
		item.data = data_byte;
		item.code = CODE_W'(code_index);
		item.mode = MODE_W'(mode_index);
		item.pos  = POS_W'(seq_pos);
		keep      = 1'b1;
		case (req_type)
			REQ_LD_CSEQ: begin
				item.kind = K_LD_CSEQ;
				keep      = int'(seq_pos) < SEQ_LEN;
			end
			REQ_LD_CMODE: begin
				item.kind = K_LD_CMODE;
				item.data = 8'(mode_mod(data_byte));
			end
			REQ_LD_MSEQ: begin
				item.kind = which_seq ? K_LD_END : K_LD_START;
				keep      = (int'(mode_index) < MODES) && (int'(seq_pos) < SEQ_LEN);
			end
			default: begin
				if (data_byte == BYTE_NULL) begin
					item.kind = K_PR_NULL;
				end else if (data_byte inside {[BYTE_EXT:BYTE_TOP]}) begin
					item.kind = K_PR_EXT;
				end else begin
					item.kind = K_PR_PLAIN;
				end
			end
		endcase
	end

	// Loads that fall outside the tables are accepted and dropped here.
	assign in_stall = flow.full || flow.clearing;
	assign push     = in_valid && !in_stall && keep;

endmodule

// ----- hdl/pct_queue.sv -----
// Two-entry queue of classified items between front and back end.
// Depends on pct_pkg.
module pct_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pct_pkg::item_t  item_in,
	input  logic            pop,
	output pct_pkg::item_t  head,
	output logic            valid,
	output logic            full
);
	import pct_pkg::*;

	item_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= item_in;
		end
	end

	assign head  = entry_q[rd_q];
	assign valid = cnt_q != 2'd0;
	assign full  = cnt_q == 2'd2;

endmodule

// ----- hdl/pct_back.sv -----
// Back end of the printer code translator: table memories, sequencer and output register.
// Depends on pct_pkg; takes items from pct_queue.
module pct_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pct_pkg::item_t  head,
	output logic            q_pop,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            last
);
	import pct_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD1   = 3'd2;
	localparam logic [2:0] ST_RD2   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]        state_q;
	logic [CODE_W-1:0] clr_q;
	logic [MODE_W-1:0] cur_q;

	row_t              cseq_mem  [EXT_CODES];
	logic [MODE_W-1:0] cmode_mem [EXT_CODES];
	row_t              start_mem [MODES];
	row_t              end_mem   [MODES];

	row_t              cseq_rd_q;
	row_t              start_rd_q;
	row_t              end_rd_q;
	logic [MODE_W-1:0] cmode_rd_q;

	item_t             it_q;
	logic [MODE_W-1:0] target_q;
	logic              sw_q;
	logic              en2_q;
	row_t              seg_q [3];
	logic [2:0]        ne_q;
	logic [1:0]        sel_q;
	logic [POS_W-1:0]  pos_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              last_q;

	logic              clr;
	logic              is_print;
	logic [CODE_W-1:0] rd_code;
	logic              sw_d;
	logic              en2_d;
	logic [MODE_W-1:0] tgt_d;
	row_t              seg2_d;
	logic [2:0]        ne_d;
	row_t              cur_row;
	logic [7:0]        cur_byte;
	logic [POS_W-1:0]  nxt_pos;
	logic              at_end;
	logic              later;
	logic [1:0]        nxt_sel;
	logic              load_out;
	logic              fire;

	assign clr      = state_q == ST_CLEAR;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign is_print = (head.kind == K_PR_NULL) || (head.kind == K_PR_EXT) ||
	                  (head.kind == K_PR_PLAIN);
	assign rd_code  = head.data[CODE_W-1:0];
	assign clearing = clr;

	// Mode decision once the code's mode has been read.
	always_comb begin
		sw_d   = 1'b0;
		en2_d  = 1'b1;
		tgt_d  = cur_q;
		seg2_d = '0;
		seg2_d[0] = ((it_q.kind == K_PR_NULL) || (it_q.data == 8'd0)) ? BYTE_NULL : it_q.data;
		case (it_q.kind)
			K_PR_EXT: begin
				sw_d   = (cmode_rd_q != cur_q) && (cmode_rd_q != '0);
				en2_d  = (cmode_rd_q == cur_q) || sw_d;
				tgt_d  = cmode_rd_q;
				seg2_d = cseq_rd_q;
			end
			K_PR_PLAIN: begin
				sw_d  = cur_q != '0;
				tgt_d = '0;
			end
			default: begin
				sw_d = 1'b0;
			end
		endcase
	end

	assign ne_d[0] = sw_q && !is_space(seg_q[0]) && (seg_q[0][0] != 8'd0);
	assign ne_d[1] = sw_q && !is_space(start_rd_q) && (start_rd_q[0] != 8'd0);
	assign ne_d[2] = en2_q && (seg_q[2][0] != 8'd0);

	always_comb begin
		cur_row  = seg_q[sel_q];
		cur_byte = cur_row[pos_q];
		nxt_pos  = (int'(pos_q) == SEQ_LEN - 1) ? '0 : pos_q + POS_W'(1);
		at_end   = (int'(pos_q) == SEQ_LEN - 1) || (cur_row[nxt_pos] == 8'd0);
		later    = 1'b0;
		nxt_sel  = 2'd2;
		case (sel_q)
			2'd0: begin
				later   = ne_q[1] || ne_q[2];
				nxt_sel = ne_q[1] ? 2'd1 : 2'd2;
			end
			2'd1: begin
				later = ne_q[2];
			end
			default: begin
				later = 1'b0;
			end
		endcase
	end

	assign load_out = !out_valid_q || !out_stall;
	assign fire     = (state_q == ST_EMIT) && load_out;

	// Table memories, each with one write and one registered read.
	always_ff @(posedge clk) begin
		if (clr) begin
			cseq_mem[clr_q] <= '0;
		end else if (q_pop && (head.kind == K_LD_CSEQ)) begin
			cseq_mem[head.code][head.pos] <= head.data;
		end
		if (q_pop) begin
			cseq_rd_q <= cseq_mem[rd_code];
		end
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			cmode_mem[clr_q] <= '0;
		end else if (q_pop && (head.kind == K_LD_CMODE)) begin
			cmode_mem[head.code] <= head.data[MODE_W-1:0];
		end
		if (q_pop) begin
			cmode_rd_q <= cmode_mem[rd_code];
		end
	end

	always_ff @(posedge clk) begin
		if (clr && (int'(clr_q) < MODES)) begin
			start_mem[MODE_W'(clr_q)] <= '0;
		end else if (q_pop && (head.kind == K_LD_START)) begin
			start_mem[head.mode][head.pos] <= head.data;
		end
		if (state_q == ST_RD1) begin
			start_rd_q <= start_mem[tgt_d];
		end
	end

	always_ff @(posedge clk) begin
		if (clr && (int'(clr_q) < MODES)) begin
			end_mem[MODE_W'(clr_q)] <= '0;
		end else if (q_pop && (head.kind == K_LD_END)) begin
			end_mem[head.mode][head.pos] <= head.data;
		end
		if (q_pop) begin
			end_rd_q <= end_mem[cur_q];
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CODE_W'(1);
					if (clr_q == CODE_W'(EXT_CODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop && is_print) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (sw_q) begin
						cur_q <= target_q;
					end
					state_q <= (ne_d == 3'd0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (fire && at_end && !later) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequencer data path.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= head;
		end
		if (state_q == ST_RD1) begin
			seg_q[0] <= end_rd_q;
			seg_q[2] <= seg2_d;
			sw_q     <= sw_d;
			en2_q    <= en2_d;
			target_q <= tgt_d;
		end
		if (state_q == ST_RD2) begin
			seg_q[1] <= start_rd_q;
			ne_q     <= ne_d;
			pos_q    <= '0;
			sel_q    <= ne_d[0] ? 2'd0 : (ne_d[1] ? 2'd1 : 2'd2);
		end
		if (fire) begin
			out_byte_q <= (cur_byte == BYTE_NULL) ? 8'd0 : cur_byte;
			last_q     <= at_end && !later;
			if (at_end) begin
				sel_q <= nxt_sel;
				pos_q <= '0;
			end else begin
				pos_q <= nxt_pos;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

// ----- hdl/printer_code_translator.sv -----
// Printer code translator: a print byte sent alone in mode 0 passes through the queue, the
// back end read states ST_RD1 and ST_RD2 and the output register, and the back end takes the
// next item only once it is through. Mode switches and escape codes then send one word per
// cycle while out_stall is low; load words are written without leaving ST_IDLE. The back
// end sequencer reads the table memories in two steps. After reset a clearing pass over the
// 128 code entries zeroes the tables with in_stall high; control state resets asynchronously.
module printer_code_translator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	input  logic [6:0] code_index,
	input  logic [2:0] mode_index,
	input  logic       which_seq,
	input  logic [2:0] seq_pos,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);
	import pct_pkg::*;

	// The front end classifies each word and drops loads that fall outside the tables.
	// Classified items wait in a short queue, so input words keep arriving while the
	// back end is still sending a sequence or the printer side is stalling.
	flow_t flow;
	item_t push_item;
	item_t head;
	logic  push;
	logic  q_pop;
	logic  q_valid;
	logic  q_full;
	logic  clearing;

	assign flow.full     = q_full;
	assign flow.clearing = clearing;

	pct_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.code_index (code_index),
		.mode_index (mode_index),
		.which_seq  (which_seq),
		.seq_pos    (seq_pos),
		.flow       (flow),
		.push       (push),
		.item       (push_item)
	);

	pct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (push_item),
		.pop     (q_pop),
		.head    (head),
		.valid   (q_valid),
		.full    (q_full)
	);

	// The back end owns the tables and the current mode. It handles items strictly in
	// order, so a load is always seen by every later print word.
	pct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

	// No word may be taken while the tables are being cleared.
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("input word accepted during clearing pass");

	// A full queue must hold the input side back.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> in_stall)
		else $error("input side open while queue is full");

	// Nothing reaches the printer before the tables are clear.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("output word during clearing pass");

	// The back end only takes from a queue that holds an item.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
